[hw/rtl/lifo_stack_search_remove_macros.svh]
// Assertion macros for the stack block.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef LIFO_STACK_SEARCH_REMOVE_MACROS_SVH
`define LIFO_STACK_SEARCH_REMOVE_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define LSSR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is held.
`define LSSR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/lssr_pkg.sv]
// Shared types and codes for the search-and-remove stack.
// No dependencies; used by every module of the block.
`default_nettype none

package lssr_pkg;

    localparam int DATA_W = 32;
    localparam int POS_W  = 7;

    // Command codes
    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_POP   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_FIND  = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    // Per-cell update operation
    typedef logic [1:0] t_cell_op;
    localparam t_cell_op CELL_HOLD       = 2'd0;
    localparam t_cell_op CELL_FROM_ABOVE = 2'd1;
    localparam t_cell_op CELL_FROM_BELOW = 2'd2;

    typedef struct packed {
        logic [1:0]               command;
        logic signed [DATA_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic signed [DATA_W-1:0] popped_value;
        logic [POS_W-1:0]         position;
        logic [1:0]               status;
        logic [POS_W-1:0]         entry_count;
        logic                     is_empty;
    } t_rsp;

endpackage

`default_nettype wire

[hw/rtl/lssr_cell.sv]
// One storage cell of the stack chain: holds a word, compares it to the key.
// Depends on lssr_pkg for the word width and cell operation codes.
`default_nettype none

module lssr_cell (
    input  wire logic                              i_clk,
    input  wire lssr_pkg::t_cell_op                i_op,
    input  wire logic signed [lssr_pkg::DATA_W-1:0] i_above,
    input  wire logic signed [lssr_pkg::DATA_W-1:0] i_below,
    input  wire logic signed [lssr_pkg::DATA_W-1:0] i_key,
    output logic signed [lssr_pkg::DATA_W-1:0]      o_word,
    output logic                                   o_match
);

    logic signed [lssr_pkg::DATA_W-1:0] r_word;

    // Take the neighbor's word or hold
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            lssr_pkg::CELL_FROM_ABOVE: r_word <= i_above;
            lssr_pkg::CELL_FROM_BELOW: r_word <= i_below;
            default:                   r_word <= r_word;
        endcase
    end

    assign o_word  = r_word;
    assign o_match = (r_word == i_key);

endmodule

`default_nettype wire

[hw/rtl/lssr_pick.sv]
// Picks the topmost matching cell and the cells that close the gap below it.
// Depends on lssr_pkg for the word width.
`default_nettype none

module lssr_pick #(
    parameter int STACK_DEPTH = 64,
    parameter int CNT_W       = 7
) (
    input  wire logic [STACK_DEPTH-1:0]                      i_match,
    input  wire logic [STACK_DEPTH-1:0][lssr_pkg::DATA_W-1:0] i_words,
    output logic                                             o_hit,
    output logic [STACK_DEPTH-1:0]                           o_shift,
    output logic signed [lssr_pkg::DATA_W-1:0]               o_value,
    output logic [CNT_W-1:0]                                 o_pos
);

    logic [STACK_DEPTH-1:0] low_mask;
    logic [STACK_DEPTH-1:0] onehot;

    // Bits from the top cell down to the first match, then the match alone
    assign low_mask = i_match ^ (i_match - STACK_DEPTH'(1));
    assign onehot   = low_mask & i_match;
    assign o_hit    = |i_match;
    // The match and every cell below it move up by one
    assign o_shift  = ~low_mask | onehot;

    // Select the matching word and encode its depth from the top
    always_comb begin
        o_value = '0;
        o_pos   = '0;
        for (int k = 0; k < STACK_DEPTH; k++) begin
            if (onehot[k]) begin
                o_value = o_value | i_words[k];
                o_pos   = o_pos | CNT_W'(k + 1);
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/lifo_stack_search_remove.sv]
// Bounded LIFO stack of signed 32-bit words with find-and-remove.
// Requests arrive on i_req (valid/ready), one response per request leaves on
// o_rsp (valid/ready). Commands: push, pop, clear, find topmost match and remove.
// The stack is a chain of register cells, top entry in cell 0; push shifts the
// chain down, pop shifts it up, and a removal shifts up only the cells from the
// match downward. Every cell compares itself with the key in the request cycle.
// Push, pop and clear load the response register in the cycle of acceptance;
// find first registers the match vector and the find state, then resolves the
// topmost hit and loads the response register. Throughput: one request per cycle
// for push, pop and clear while responses are taken; none is taken during a find.
// A new request is taken in the cycle the held response is taken, so a stalled
// receiver stops acceptance until the response register drains.
// Reset (synchronous, active low) empties the stack and drops any pending
// response; cell contents are not cleared and never read before being written.
// Depends on lssr_pkg, lssr_cell, lssr_pick and the assertion macro header.
`default_nettype none
`include "lifo_stack_search_remove_macros.svh"

module lifo_stack_search_remove #(
    parameter int STACK_DEPTH = 64
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_req_valid,
    output logic                o_req_ready,
    input  wire lssr_pkg::t_req i_req,
    output logic                o_rsp_valid,
    input  wire logic           i_rsp_ready,
    output lssr_pkg::t_rsp      o_rsp
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_FIND = 1'b1;

    logic                                       r_state, n_state;
    logic [CNT_W-1:0]                           r_count, n_count;
    logic [STACK_DEPTH-1:0]                     r_match;
    logic                                       r_rsp_valid;
    lssr_pkg::t_rsp                             r_rsp, n_rsp;
    logic                                       load_rsp;
    logic                                       req_fire;

    lssr_pkg::t_cell_op [STACK_DEPTH-1:0]       cell_op;
    logic [STACK_DEPTH-1:0][lssr_pkg::DATA_W-1:0] cell_word;
    logic [STACK_DEPTH-1:0]                     cell_match;
    logic [STACK_DEPTH-1:0]                     live_match;

    logic                                       pick_hit;
    logic [STACK_DEPTH-1:0]                     pick_shift;
    logic signed [lssr_pkg::DATA_W-1:0]         pick_value;
    logic [CNT_W-1:0]                           pick_pos;

    // Cell chain
    for (genvar k = 0; k < STACK_DEPTH; k++) begin : g_cell
        logic signed [lssr_pkg::DATA_W-1:0] above;
        logic signed [lssr_pkg::DATA_W-1:0] below;
        if (k == 0) begin : g_top
            assign above = i_req.value;
        end else begin : g_mid
            assign above = cell_word[k-1];
        end
        if (k == STACK_DEPTH - 1) begin : g_bot
            assign below = '0;
        end else begin : g_up
            assign below = cell_word[k+1];
        end

        lssr_cell u_cell (
            .i_clk   (i_clk),
            .i_op    (cell_op[k]),
            .i_above (above),
            .i_below (below),
            .i_key   (i_req.value),
            .o_word  (cell_word[k]),
            .o_match (cell_match[k])
        );

        // Only occupied cells may match
        assign live_match[k] = cell_match[k] && (r_count > CNT_W'(k));
    end

    lssr_pick #(
        .STACK_DEPTH (STACK_DEPTH),
        .CNT_W       (CNT_W)
    ) u_pick (
        .i_match (r_match),
        .i_words (cell_word),
        .o_hit   (pick_hit),
        .o_shift (pick_shift),
        .o_value (pick_value),
        .o_pos   (pick_pos)
    );

    assign o_req_ready = (r_state == S_IDLE) && (!r_rsp_valid || i_rsp_ready);
    assign req_fire    = i_req_valid && o_req_ready;

    // Command decode and chain control
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        load_rsp = 1'b0;
        n_rsp    = '0;
        for (int k = 0; k < STACK_DEPTH; k++) begin
            cell_op[k] = lssr_pkg::CELL_HOLD;
        end
        n_rsp.status = lssr_pkg::ST_OK;

        unique case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    unique case (i_req.command)
                        lssr_pkg::CMD_PUSH: begin
                            load_rsp = 1'b1;
                            if (r_count == CNT_W'(STACK_DEPTH)) begin
                                n_rsp.status = lssr_pkg::ST_OVERFLOW;
                            end else begin
                                for (int k = 0; k < STACK_DEPTH; k++) begin
                                    cell_op[k] = lssr_pkg::CELL_FROM_ABOVE;
                                end
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        lssr_pkg::CMD_POP: begin
                            load_rsp = 1'b1;
                            if (r_count == '0) begin
                                n_rsp.status = lssr_pkg::ST_UNDERFLOW;
                            end else begin
                                for (int k = 0; k < STACK_DEPTH; k++) begin
                                    cell_op[k] = lssr_pkg::CELL_FROM_BELOW;
                                end
                                n_rsp.popped_value = cell_word[0];
                                n_count = r_count - CNT_W'(1);
                            end
                        end
                        lssr_pkg::CMD_CLEAR: begin
                            load_rsp = 1'b1;
                            n_count  = '0;
                        end
                        lssr_pkg::CMD_FIND: begin
                            n_state = S_FIND;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_FIND: begin
                load_rsp = 1'b1;
                n_state  = S_IDLE;
                if (pick_hit) begin
                    for (int k = 0; k < STACK_DEPTH; k++) begin
                        if (pick_shift[k]) begin
                            cell_op[k] = lssr_pkg::CELL_FROM_BELOW;
                        end
                    end
                    n_rsp.popped_value = pick_value;
                    n_rsp.position     = lssr_pkg::POS_W'(pick_pos);
                    n_count            = r_count - CNT_W'(1);
                end else begin
                    n_rsp.status = lssr_pkg::ST_NOT_FOUND;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_rsp.entry_count = lssr_pkg::POS_W'(n_count);
        n_rsp.is_empty    = (n_count == '0);
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (load_rsp) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // Payload: capture the match vector and the response
    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_match <= live_match;
        end
        if (load_rsp) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    `LSSR_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_W'(STACK_DEPTH), "entry count above depth")
    `LSSR_ASSERT_NEXT(a_find_done, r_state == S_FIND, r_rsp_valid && r_state == S_IDLE, "find did not complete")
    `LSSR_ASSERT_NOW(a_no_overwrite, r_rsp_valid && !i_rsp_ready, !load_rsp, "stalled response overwritten")
    `LSSR_ASSERT_NEXT(a_count_quiet, !load_rsp, $stable(r_count), "count changed without a response")

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for lifo_stack_search_remove: directed and random requests
// over valid/ready, checked against a scoreboard that mirrors the stack contents.
// Depends on lssr_pkg and the block's RTL.
module tb;
    import lssr_pkg::*;

    localparam int STACK_DEPTH  = 64;
    localparam int RANDOM_ITEMS = 1500;
    localparam int DRAIN_CYCLES = 10;

    // Flavors of random bursts
    localparam int BURST_GROW   = 0;
    localparam int BURST_SHRINK = 1;
    localparam int BURST_MIXED  = 2;

    // Mirror of the stack: predicts one response per accepted request
    class lifo_scoreboard;
        logic signed [DATA_W-1:0] words [STACK_DEPTH];
        int                       held;
        t_rsp                     expected_rsps [$];
        int                       errors;

        function new();
            held   = 0;
            errors = 0;
        endfunction

        function void note_request(t_req req);
            t_rsp rsp;
            int   hit;
            rsp        = '0;
            rsp.status = ST_OK;
            case (req.command)
                CMD_PUSH: begin
                    if (held >= STACK_DEPTH) begin
                        rsp.status = ST_OVERFLOW;
                    end else begin
                        words[held] = req.value;
                        held++;
                    end
                end
                CMD_POP: begin
                    if (held == 0) begin
                        rsp.status = ST_UNDERFLOW;
                    end else begin
                        held--;
                        rsp.popped_value = words[held];
                    end
                end
                CMD_CLEAR: begin
                    held = 0;
                end
                CMD_FIND: begin
                    // Search from the top, remove the first match and close the gap
                    hit = -1;
                    for (int i = held - 1; i >= 0; i--) begin
                        if (words[i] == req.value) begin
                            hit = i;
                            break;
                        end
                    end
                    if (hit < 0) begin
                        rsp.status = ST_NOT_FOUND;
                    end else begin
                        rsp.popped_value = words[hit];
                        rsp.position     = POS_W'(held - hit);
                        for (int k = hit; k + 1 < held; k++) words[k] = words[k + 1];
                        held--;
                    end
                end
            endcase
            rsp.entry_count = POS_W'(held);
            rsp.is_empty    = (held == 0);
            expected_rsps.push_back(rsp);
        endfunction

        function void check_field(string name, logic [DATA_W-1:0] want,
                                  logic [DATA_W-1:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch: expected %0h, actual %0h",
                         $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_response(t_rsp got);
            t_rsp want;
            if (expected_rsps.size() == 0) begin
                $display("%0t: unexpected response: expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = expected_rsps.pop_front();
            check_field("popped_value", want.popped_value, got.popped_value);
            check_field("position", want.position, got.position);
            check_field("status", want.status, got.status);
            check_field("entry_count", want.entry_count, got.entry_count);
            check_field("is_empty", want.is_empty, got.is_empty);
        endfunction
    endclass

    logic           i_clk = 1'b0;
    logic           i_rst_n;
    logic           i_req_valid;
    logic           o_req_ready;
    t_req           i_req;
    logic           o_rsp_valid;
    logic           i_rsp_ready;
    t_rsp           o_rsp;

    lifo_scoreboard sb;
    bit             steady = 1'b0;   // both sides run without gaps
    int             rsp_stall = 0;

    lifo_stack_search_remove #(
        .STACK_DEPTH (STACK_DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Idle length: mostly none or short, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady) return 0;
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Stall the response side at random
    always @(posedge i_clk) begin
        if (rsp_stall > 0) begin
            rsp_stall   <= rsp_stall - 1;
            i_rsp_ready <= 1'b0;
        end else if (!steady && $urandom_range(0, 3) == 0) begin
            rsp_stall   <= pick_gap();
            i_rsp_ready <= 1'b0;
        end else begin
            i_rsp_ready <= 1'b1;
        end
    end

    // Check every accepted response
    always @(posedge i_clk) begin
        if (i_rst_n && o_rsp_valid && i_rsp_ready) sb.check_response(o_rsp);
    end

    // Offer one request after a random gap and hold it until accepted
    task automatic send_request(input t_req req);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= req;
        do @(posedge i_clk); while (!o_req_ready);
        sb.note_request(req);
    endtask

    // Hold off the sender until every expected response has arrived
    task automatic wait_drained();
        i_req_valid <= 1'b0;
        do @(posedge i_clk); while (sb.expected_rsps.size() != 0);
    endtask

    function automatic t_req build_request(logic [1:0] command, logic [DATA_W-1:0] value);
        t_req req;
        req.command = command;
        req.value   = value;
        return req;
    endfunction

    // Word source: small values and near-extremes repeat often, so duplicates occur
    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0, 1, 2: return DATA_W'($urandom_range(0, 6) - 3);
            3:       return {1'b1, 31'($urandom_range(0, 3))};
            4:       return {1'b0, {31{1'b1}}} - DATA_W'($urandom_range(0, 3));
            default: return $urandom();
        endcase
    endfunction

    function automatic t_req make_request(int flavor);
        t_req req;
        int   roll;
        int   idx;
        roll = $urandom_range(0, 99);
        case (flavor)
            BURST_GROW:
                req.command = roll < 85 ? CMD_PUSH : roll < 92 ? CMD_POP : CMD_FIND;
            BURST_SHRINK:
                req.command = roll < 8 ? CMD_PUSH : roll < 50 ? CMD_POP :
                              roll < 97 ? CMD_FIND : CMD_CLEAR;
            default:
                req.command = roll < 35 ? CMD_PUSH : roll < 60 ? CMD_POP :
                              roll < 96 ? CMD_FIND : CMD_CLEAR;
        endcase
        req.value = pick_word();
        // Aim most searches at a held entry, favoring the top and the bottom
        if (req.command == CMD_FIND && sb.held > 0 && $urandom_range(0, 9) < 7) begin
            roll = $urandom_range(0, 3);
            idx  = roll == 0 ? 0 : roll == 1 ? sb.held - 1 : $urandom_range(0, sb.held - 1);
            req.value = sb.words[idx];
        end
        return req;
    endfunction

    initial begin
        int sent;
        int burst;
        int burst_len;
        int flavor;
        sb = new();
        i_rst_n     <= 1'b0;
        i_req_valid <= 1'b0;
        i_req       <= '0;
        i_rsp_ready <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty-stack cases: underflow, search miss, clear
        send_request(build_request(CMD_POP, 32'h0));
        send_request(build_request(CMD_FIND, 32'h0));
        send_request(build_request(CMD_CLEAR, 32'hFFFF_FFFF));
        // Extremes, with a duplicate of the maximum
        send_request(build_request(CMD_PUSH, 32'h8000_0000));
        send_request(build_request(CMD_PUSH, 32'h7FFF_FFFF));
        send_request(build_request(CMD_PUSH, 32'h0));
        send_request(build_request(CMD_PUSH, 32'hFFFF_FFFF));
        send_request(build_request(CMD_PUSH, 32'h7FFF_FFFF));
        // Topmost duplicate first, then the deeper one, then the bottom entry
        send_request(build_request(CMD_FIND, 32'h7FFF_FFFF));
        send_request(build_request(CMD_FIND, 32'h7FFF_FFFF));
        send_request(build_request(CMD_FIND, 32'h8000_0000));
        send_request(build_request(CMD_FIND, 32'h1234_5678));
        send_request(build_request(CMD_POP, 32'h5555_5555));
        send_request(build_request(CMD_PUSH, 32'h5555_5555));
        send_request(build_request(CMD_PUSH, 32'hAAAA_AAAA));
        send_request(build_request(CMD_FIND, 32'h0));
        send_request(build_request(CMD_CLEAR, 32'h0));
        send_request(build_request(CMD_POP, 32'h0));
        send_request(build_request(CMD_FIND, 32'hAAAA_AAAA));

        // Random bursts; the first one grows the stack
        sent  = 0;
        burst = 0;
        while (sent < RANDOM_ITEMS) begin
            flavor    = (burst == 0) ? BURST_GROW : $urandom_range(BURST_GROW, BURST_MIXED);
            burst_len = (flavor == BURST_GROW) ? $urandom_range(70, 100)
                                               : $urandom_range(20, 80);
            steady    = ($urandom_range(0, 4) == 0);
            if (burst % 6 == 5) wait_drained();
            repeat (burst_len) begin
                send_request(make_request(flavor));
                sent++;
            end
            burst++;
        end
        steady = 1'b0;

        // Drain and let any stray response show up
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
